[src/space_vector_pwm_duty_unit_defines.svh]
// ----------------------------------------------------------------------------
// Space vector PWM duty unit: assertion macros
// Shared assertion shorthands for the checker of the duty unit.
// ----------------------------------------------------------------------------
`ifndef SPACE_VECTOR_PWM_DUTY_UNIT_DEFINES_SVH
`define SPACE_VECTOR_PWM_DUTY_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define SVPD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SVPD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also watches the reset itself.
`define SVPD_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/svpd_pkg.sv]
// ----------------------------------------------------------------------------
// Space vector PWM duty unit package
// Constants, carried side-data types and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package svpd_pkg;

  localparam int CORDIC_STAGES_DEF  = 16;
  localparam int DUTY_FRAC_BITS_DEF = 15;
  localparam int ATAN_LEN           = 24;
  localparam int MAX_FRAC_BITS      = 20;
  localparam int MQ_W               = MAX_FRAC_BITS + 1;

  localparam logic [31:0] GAIN_INV      = 32'h9B74EDA8;
  localparam logic [31:0] ROT_X0        = GAIN_INV >> 2;
  localparam logic [15:0] INV_SQRT3_Q16 = 16'd37837;
  localparam logic [31:0] RECIP6        = 32'hAAAAAAAB;
  localparam logic [31:0] SIXTH_TURN    = 32'd715827882;
  localparam logic [31:0] HALF_TURN     = 32'h80000000;
  localparam logic [30:0] DEN_RESET     = 31'd387450880;

  // Side data that rides along the divider cells.
  typedef struct packed {
    logic [2:0]  idx;
    logic        over;
    logic        dzero;
    logic [31:0] ang1;
    logic [31:0] ang2;
  } dside_t;

  // Side data that rides along the rotation cells.
  typedef struct packed {
    logic [2:0]      idx;
    logic            over;
    logic [MQ_W-1:0] m;
  } rside_t;

  function automatic logic [31:0] atan_bin(input int i);
    logic [31:0] v;
    case (i)
      0:       v = 32'h20000000;
      1:       v = 32'h12E4051E;
      2:       v = 32'h09FB385B;
      3:       v = 32'h051111D4;
      4:       v = 32'h028B0D43;
      5:       v = 32'h0145D7E1;
      6:       v = 32'h00A2F61E;
      7:       v = 32'h00517C55;
      8:       v = 32'h0028BE53;
      9:       v = 32'h00145F2F;
      10:      v = 32'h000A2F98;
      11:      v = 32'h000517CC;
      12:      v = 32'h00028BE6;
      13:      v = 32'h000145F3;
      14:      v = 32'h0000A2FA;
      15:      v = 32'h0000517D;
      16:      v = 32'h000028BE;
      17:      v = 32'h0000145F;
      18:      v = 32'h00000A30;
      19:      v = 32'h00000518;
      20:      v = 32'h0000028C;
      21:      v = 32'h00000146;
      22:      v = 32'h000000A3;
      default: v = 32'h00000051;
    endcase
    return v;
  endfunction

endpackage

[src/space_vector_pwm_duty_unit.sv]
// ----------------------------------------------------------------------------
// Space vector PWM duty unit
// Turns an alpha/beta voltage vector into three centered phase duties.
// ----------------------------------------------------------------------------
// The unit takes one (alpha, beta) vector per clock and returns one result
// per vector, in order. S is the number of CORDIC stages run (at most 24)
// and F is DUTY_FRAC_BITS. The chain of cells is: S vectoring cells, the
// gain, overdrive and angle registers, F+1 divider cells for the modulation
// index, S rotation cells for the two sines, then the time and output
// registers. When the result port stalls, the whole chain holds. The bus
// limit register may be written at any time the unit is idle.
module space_vector_pwm_duty_unit #(
  parameter int CORDIC_STAGES  = svpd_pkg::CORDIC_STAGES_DEF,
  parameter int DUTY_FRAC_BITS = svpd_pkg::DUTY_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [14:0]        cfg_bus_limit,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_v_alpha,
  input  logic signed [15:0] in_v_beta,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_duty_a,
  output logic [15:0]        out_duty_b,
  output logic [15:0]        out_duty_c,
  output logic [2:0]         out_sector,
  output logic               out_over_modulated
);

  localparam int NST  = (CORDIC_STAGES < svpd_pkg::ATAN_LEN) ?
                        CORDIC_STAGES : svpd_pkg::ATAN_LEN;
  localparam int NDIV = DUTY_FRAC_BITS + 1;
  localparam int MW   = svpd_pkg::MQ_W;
  localparam int TW   = MW + 1;
  localparam int SW   = TW + 2;
  localparam logic [MW-1:0] ONE_M = MW'(1) << DUTY_FRAC_BITS;
  localparam logic [SW-1:0] ONE_S = SW'(1) << DUTY_FRAC_BITS;
  localparam logic [SW-1:0] DUTY_MAX = SW'(16'hFFFF);

  localparam logic [2:0] SEC_1 = 3'd0;
  localparam logic [2:0] SEC_2 = 3'd1;
  localparam logic [2:0] SEC_3 = 3'd2;
  localparam logic [2:0] SEC_4 = 3'd3;
  localparam logic [2:0] SEC_5 = 3'd4;

  logic en;
  logic out_valid_r;

  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  // Configuration: keep the bus limit already scaled by 1/sqrt(3).
  logic [30:0] den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      den_r <= svpd_pkg::DEN_RESET;
    end else if (cfg_valid) begin
      den_r <= {16'b0, cfg_bus_limit} * {15'b0, svpd_pkg::INV_SQRT3_Q16};
    end
  end

  // Input fold into the right half plane.
  logic signed [31:0] xp, yp;
  logic               neg;

  assign xp  = {{4{in_v_alpha[15]}}, in_v_alpha, 12'b0};
  assign yp  = {{4{in_v_beta[15]}}, in_v_beta, 12'b0};
  assign neg = xp[31];

  logic signed [31:0] vx [0:NST];
  logic signed [31:0] vy [0:NST];
  logic        [31:0] vth [0:NST];
  logic               vz [0:NST];
  logic               vv [0:NST];

  assign vx[0]  = neg ? -xp : xp;
  assign vy[0]  = neg ? -yp : yp;
  assign vth[0] = neg ? svpd_pkg::HALF_TURN : 32'd0;
  assign vz[0]  = (in_v_alpha == 16'sd0) && (in_v_beta == 16'sd0);
  assign vv[0]  = in_valid;

  for (genvar i = 0; i < NST; i++) begin : g_vec
    svpd_vec_cell #(.SHIFT(i)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_i(vv[i]), .x_i(vx[i]), .y_i(vy[i]), .th_i(vth[i]), .zero_i(vz[i]),
      .vld_o(vv[i+1]), .x_o(vx[i+1]), .y_o(vy[i+1]), .th_o(vth[i+1]),
      .zero_o(vz[i+1])
    );
  end

  // Magnitude gain correction and sector split.
  logic [31:0] x_cl, th_f;
  logic [63:0] mag_prod;
  logic [34:0] six;
  logic        p1_vld_r;
  logic [31:0] mag_r, rel_r;
  logic [2:0]  p1_idx_r;

  assign x_cl     = (vx[NST][31] || vz[NST]) ? 32'd0 : vx[NST];
  assign mag_prod = {32'b0, x_cl} * {32'b0, svpd_pkg::GAIN_INV};
  assign th_f     = vz[NST] ? 32'd0 : vth[NST];
  assign six      = ({3'b0, th_f} << 2) + ({3'b0, th_f} << 1);

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r    <= mag_prod[63:32];
      p1_idx_r <= six[34:32];
      rel_r    <= six[31:0];
    end
  end

  // Overdrive check and division of the in-sector angle by six.
  logic [35:0] num;
  logic        over;
  logic [63:0] q_prod;
  logic        p2_vld_r, p2_over_r;
  logic [2:0]  p2_idx_r;
  logic [30:0] p2_num_r;
  logic [31:0] p2_rel_r, p2_q_r;

  assign num    = {mag_r, 4'b0};
  assign over   = num > {5'b0, den_r};
  assign q_prod = {32'b0, rel_r} * {32'b0, svpd_pkg::RECIP6};

  always_ff @(posedge clk) begin
    if (en) begin
      p2_idx_r  <= p1_idx_r;
      p2_over_r <= over;
      p2_num_r  <= over ? 31'd0 : num[30:0];
      p2_rel_r  <= rel_r;
      p2_q_r    <= {2'b0, q_prod[63:34]};
    end
  end

  // The complementary angle: (turn/6 * 6 - rel) / 6 with the carried remainder.
  logic [31:0] sixq, sdiff;
  logic        adj;
  logic        p3_vld_r;
  logic [30:0] p3_num_r;
  svpd_pkg::dside_t p3_side_r;

  assign sixq  = (p2_q_r << 2) + (p2_q_r << 1);
  assign sdiff = p2_rel_r - sixq;
  assign adj   = sdiff[2:0] == 3'd5;

  always_ff @(posedge clk) begin
    if (en) begin
      p3_num_r        <= p2_num_r;
      p3_side_r.idx   <= p2_idx_r;
      p3_side_r.over  <= p2_over_r;
      p3_side_r.dzero <= den_r == 31'd0;
      p3_side_r.ang1  <= svpd_pkg::SIXTH_TURN - p2_q_r - {31'b0, adj};
      p3_side_r.ang2  <= p2_q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      p3_vld_r <= 1'b0;
    end else if (en) begin
      p1_vld_r <= vv[NST];
      p2_vld_r <= p1_vld_r;
      p3_vld_r <= p2_vld_r;
    end
  end

  // Modulation index divider.
  logic [31:0]      drem [0:NDIV];
  logic [MW-1:0]    dquo [0:NDIV];
  svpd_pkg::dside_t dsd  [0:NDIV];
  logic             dv   [0:NDIV];

  assign drem[0] = {1'b0, p3_num_r};
  assign dquo[0] = '0;
  assign dsd[0]  = p3_side_r;
  assign dv[0]   = p3_vld_r;

  for (genvar k = 0; k < NDIV; k++) begin : g_div
    svpd_div_cell #(.FIRST(k == 0)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .den_i(den_r),
      .vld_i(dv[k]), .rem_i(drem[k]), .quo_i(dquo[k]), .side_i(dsd[k]),
      .vld_o(dv[k+1]), .rem_o(drem[k+1]), .quo_o(dquo[k+1]), .side_o(dsd[k+1])
    );
  end

  // Sine lanes for t1 and t2.
  logic signed [31:0] rx1 [0:NST];
  logic signed [31:0] ry1 [0:NST];
  logic signed [31:0] rz1 [0:NST];
  logic signed [31:0] rx2 [0:NST];
  logic signed [31:0] ry2 [0:NST];
  logic signed [31:0] rz2 [0:NST];
  svpd_pkg::rside_t   rsd [0:NST];
  logic               rv  [0:NST];

  assign rx1[0]      = svpd_pkg::ROT_X0;
  assign ry1[0]      = 32'sd0;
  assign rz1[0]      = dsd[NDIV].ang1;
  assign rx2[0]      = svpd_pkg::ROT_X0;
  assign ry2[0]      = 32'sd0;
  assign rz2[0]      = dsd[NDIV].ang2;
  assign rsd[0].idx  = dsd[NDIV].idx;
  assign rsd[0].over = dsd[NDIV].over;
  assign rsd[0].m    = dsd[NDIV].over  ? ONE_M :
                       dsd[NDIV].dzero ? '0 : dquo[NDIV];
  assign rv[0]       = dv[NDIV];

  for (genvar i = 0; i < NST; i++) begin : g_rot
    svpd_rot_cell #(.SHIFT(i)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .vld_i(rv[i]),
      .x1_i(rx1[i]), .y1_i(ry1[i]), .z1_i(rz1[i]),
      .x2_i(rx2[i]), .y2_i(ry2[i]), .z2_i(rz2[i]), .side_i(rsd[i]),
      .vld_o(rv[i+1]),
      .x1_o(rx1[i+1]), .y1_o(ry1[i+1]), .z1_o(rz1[i+1]),
      .x2_o(rx2[i+1]), .y2_o(ry2[i+1]), .z2_o(rz2[i+1]), .side_o(rsd[i+1])
    );
  end

  // Active times, rounded half up.
  logic [30:0]    s1, s2;
  logic [MW+30:0] pr1, pr2;
  logic           t_vld_r, t_over_r;
  logic [2:0]     t_idx_r;
  logic [TW-1:0]  t1_r, t2_r;

  assign s1  = ry1[NST][31] ? 31'd0 :
               (ry1[NST] > 32'sd1073741824) ? 31'd1073741824 : ry1[NST][30:0];
  assign s2  = ry2[NST][31] ? 31'd0 :
               (ry2[NST] > 32'sd1073741824) ? 31'd1073741824 : ry2[NST][30:0];
  assign pr1 = {31'b0, rsd[NST].m} * {{MW{1'b0}}, s1} + (MW+31)'(32'h20000000);
  assign pr2 = {31'b0, rsd[NST].m} * {{MW{1'b0}}, s2} + (MW+31)'(32'h20000000);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_vld_r <= 1'b0;
    end else if (en) begin
      t_vld_r <= rv[NST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_idx_r  <= rsd[NST].idx;
      t_over_r <= rsd[NST].over;
      t1_r     <= pr1[30 +: TW];
      t2_r     <= pr2[30 +: TW];
    end
  end

  // Zero-vector split and the per-sector phase table.
  logic [SW-1:0] t1e, t2e, tsum, t0, h, da, db, dc;

  function automatic logic [15:0] sat_duty(input logic [SW-1:0] d);
    logic [SW-1:0] v;
    v = (d > ONE_S) ? ONE_S : d;
    v = (v > DUTY_MAX) ? DUTY_MAX : v;
    return v[15:0];
  endfunction

  assign t1e  = SW'(t1_r);
  assign t2e  = SW'(t2_r);
  assign tsum = t1e + t2e;
  assign t0   = (tsum < ONE_S) ? ONE_S - tsum : '0;
  assign h    = t0 >> 1;

  always_comb begin
    unique case (t_idx_r)
      SEC_1: begin
        da = tsum + h; db = t2e + h;  dc = h;
      end
      SEC_2: begin
        da = t1e + h;  db = tsum + h; dc = h;
      end
      SEC_3: begin
        da = h;        db = tsum + h; dc = t1e + h;
      end
      SEC_4: begin
        da = h;        db = t1e + h;  dc = tsum + h;
      end
      SEC_5: begin
        da = t2e + h;  db = h;        dc = tsum + h;
      end
      default: begin
        da = tsum + h; db = h;        dc = t1e + h;
      end
    endcase
  end

  logic [15:0] duty_a_r, duty_b_r, duty_c_r;
  logic [2:0]  sector_r;
  logic        over_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= t_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      duty_a_r <= sat_duty(da);
      duty_b_r <= sat_duty(db);
      duty_c_r <= sat_duty(dc);
      sector_r <= t_idx_r + 3'd1;
      over_r   <= t_over_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_duty_a         = duty_a_r;
  assign out_duty_b         = duty_b_r;
  assign out_duty_c         = duty_c_r;
  assign out_sector         = sector_r;
  assign out_over_modulated = over_r;

endmodule

[src/svpd_vec_cell.sv]
// ----------------------------------------------------------------------------
// Vectoring CORDIC cell
// One micro-rotation that drives y toward zero and accumulates the angle.
// ----------------------------------------------------------------------------
module svpd_vec_cell #(
  parameter int SHIFT = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_i,
  input  logic signed [31:0] x_i,
  input  logic signed [31:0] y_i,
  input  logic        [31:0] th_i,
  input  logic               zero_i,
  output logic               vld_o,
  output logic signed [31:0] x_o,
  output logic signed [31:0] y_o,
  output logic        [31:0] th_o,
  output logic               zero_o
);

  logic               vld_r;
  logic signed [31:0] x_r, y_r, x_nxt, y_nxt, xs, ys;
  logic        [31:0] th_r, th_nxt;
  logic               zero_r;

  assign xs = x_i >>> SHIFT;
  assign ys = y_i >>> SHIFT;

  always_comb begin
    if (!y_i[31]) begin
      x_nxt  = x_i + ys;
      y_nxt  = y_i - xs;
      th_nxt = th_i + svpd_pkg::atan_bin(SHIFT);
    end else begin
      x_nxt  = x_i - ys;
      y_nxt  = y_i + xs;
      th_nxt = th_i - svpd_pkg::atan_bin(SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      th_r   <= th_nxt;
      zero_r <= zero_i;
    end
  end

  assign vld_o  = vld_r;
  assign x_o    = x_r;
  assign y_o    = y_r;
  assign th_o   = th_r;
  assign zero_o = zero_r;

endmodule

[src/svpd_div_cell.sv]
// ----------------------------------------------------------------------------
// Restoring divider cell
// Produces one quotient bit of the modulation index per cell.
// ----------------------------------------------------------------------------
module svpd_div_cell #(
  parameter bit FIRST = 1'b0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic [30:0]                   den_i,
  input  logic                          vld_i,
  input  logic [31:0]                   rem_i,
  input  logic [svpd_pkg::MQ_W-1:0]     quo_i,
  input  svpd_pkg::dside_t              side_i,
  output logic                          vld_o,
  output logic [31:0]                   rem_o,
  output logic [svpd_pkg::MQ_W-1:0]     quo_o,
  output svpd_pkg::dside_t              side_o
);

  logic                      vld_r;
  logic [31:0]               cand, rem_r, rem_nxt;
  logic [svpd_pkg::MQ_W-1:0] quo_r;
  svpd_pkg::dside_t          side_r;
  logic                      qbit;

  // The remainder stays below the divisor, so doubling it fits in 32 bits.
  assign cand    = FIRST ? rem_i : {rem_i[30:0], 1'b0};
  assign qbit    = cand >= {1'b0, den_i};
  assign rem_nxt = qbit ? cand - {1'b0, den_i} : cand;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      quo_r  <= {quo_i[svpd_pkg::MQ_W-2:0], qbit};
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign rem_o  = rem_r;
  assign quo_o  = quo_r;
  assign side_o = side_r;

endmodule

[src/svpd_rot_cell.sv]
// ----------------------------------------------------------------------------
// Rotation CORDIC cell
// One micro-rotation of each of the two sine lanes.
// ----------------------------------------------------------------------------
module svpd_rot_cell #(
  parameter int SHIFT = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_i,
  input  logic signed [31:0] x1_i,
  input  logic signed [31:0] y1_i,
  input  logic signed [31:0] z1_i,
  input  logic signed [31:0] x2_i,
  input  logic signed [31:0] y2_i,
  input  logic signed [31:0] z2_i,
  input  svpd_pkg::rside_t   side_i,
  output logic               vld_o,
  output logic signed [31:0] x1_o,
  output logic signed [31:0] y1_o,
  output logic signed [31:0] z1_o,
  output logic signed [31:0] x2_o,
  output logic signed [31:0] y2_o,
  output logic signed [31:0] z2_o,
  output svpd_pkg::rside_t   side_o
);

  logic               vld_r;
  logic signed [31:0] x1_r, y1_r, z1_r, x2_r, y2_r, z2_r;
  logic signed [31:0] x1_nxt, y1_nxt, z1_nxt, x2_nxt, y2_nxt, z2_nxt;
  logic signed [31:0] at;
  svpd_pkg::rside_t   side_r;

  assign at = signed'(svpd_pkg::atan_bin(SHIFT));

  always_comb begin
    if (!z1_i[31]) begin
      x1_nxt = x1_i - (y1_i >>> SHIFT);
      y1_nxt = y1_i + (x1_i >>> SHIFT);
      z1_nxt = z1_i - at;
    end else begin
      x1_nxt = x1_i + (y1_i >>> SHIFT);
      y1_nxt = y1_i - (x1_i >>> SHIFT);
      z1_nxt = z1_i + at;
    end
    if (!z2_i[31]) begin
      x2_nxt = x2_i - (y2_i >>> SHIFT);
      y2_nxt = y2_i + (x2_i >>> SHIFT);
      z2_nxt = z2_i - at;
    end else begin
      x2_nxt = x2_i + (y2_i >>> SHIFT);
      y2_nxt = y2_i - (x2_i >>> SHIFT);
      z2_nxt = z2_i + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r   <= x1_nxt;
      y1_r   <= y1_nxt;
      z1_r   <= z1_nxt;
      x2_r   <= x2_nxt;
      y2_r   <= y2_nxt;
      z2_r   <= z2_nxt;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign x1_o   = x1_r;
  assign y1_o   = y1_r;
  assign z1_o   = z1_r;
  assign x2_o   = x2_r;
  assign y2_o   = y2_r;
  assign z2_o   = z2_r;
  assign side_o = side_r;

endmodule

[src/svpd_checker.sv]
// ----------------------------------------------------------------------------
// Space vector PWM duty unit checker
// Port-level checks on reset, stalling and the sector code.
// ----------------------------------------------------------------------------
`include "space_vector_pwm_duty_unit_defines.svh"

module svpd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_duty_a,
  input logic [2:0]  out_sector
);

  // A result that is held back stays valid and keeps its phase A duty until its transfer.
  `SVPD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_duty_a), "result changed while stalled")

  `SVPD_ASSERT_IMP(a_sector_range, out_valid, out_sector != 3'd0 && out_sector != 3'd7, "sector out of range")

  // The input side only stalls while the result side does.
  `SVPD_ASSERT_IMP(a_in_ready, out_ready || !out_valid, in_ready, "input stalled without output stall")

  `SVPD_ASSERT_RST(a_reset_empty, !rst_n, !out_valid, "result valid after reset")

endmodule

bind space_vector_pwm_duty_unit svpd_checker u_svpd_checker (.*);
